[rtl/core/tfd_pkg.sv]
package tfd_pkg;

  // Sizing
  localparam int MAX_SLOTS   = 64;
  localparam int FRAME_BYTES = 256;

  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int FLEN_W = $clog2(FRAME_BYTES + 1);
  // TLV cursor can overrun the frame by a full length byte plus header
  localparam int POS_W  = ((FLEN_W > 9) ? FLEN_W : 9) + 1;
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int IDX_W  = (SLOT_W > 6) ? SLOT_W : 6;

  // Byte codes
  localparam logic [7:0] MARK       = 8'hF8;
  localparam logic [7:0 ] TLV_GPS    = 8'h01;
  localparam logic [7:0] TLV_STATUS = 8'h03;
  localparam logic [7:0] TLV_MILE   = 8'h04;
  localparam int         TLV_START  = 10;
  localparam int         ID_FIRST   = 3;
  localparam int         ID_LAST    = 9;
  localparam int         VER_OFS    = 1;

  typedef struct packed {
    logic [5:0]  record_index;
    logic [7:0]  version_byte;
    logic [55:0] terminal_id;
    logic [15:0] status_word;
    logic        occupied_flag;
    logic        alarm_flag;
    logic [15:0] mileage;
    logic        has_gps_data;
    logic        last_of_parcel;
  } rec_t;

  typedef struct packed {
    logic load;
    rec_t rec;
  } out_ctl_t;

endpackage

[rtl/core/tfd_if.sv]
interface tfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       parcel_end;

  modport source (output valid, data_byte, parcel_end, input ready);
  modport sink   (input valid, data_byte, parcel_end, output ready);
endinterface

interface tfd_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  record_index;
  logic [7:0]  version_byte;
  logic [55:0] terminal_id;
  logic [15:0] status_word;
  logic        occupied_flag;
  logic        alarm_flag;
  logic [15:0] mileage;
  logic        has_gps_data;
  logic        last_of_parcel;

  modport source (output valid, record_index, version_byte, terminal_id, status_word,
                  occupied_flag, alarm_flag, mileage, has_gps_data, last_of_parcel,
                  input ready);
  modport sink   (input valid, record_index, version_byte, terminal_id, status_word,
                  occupied_flag, alarm_flag, mileage, has_gps_data, last_of_parcel,
                  output ready);
endinterface

[rtl/core/tfd_ram.sv]
module tfd_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/core/tfd_out_stage.sv]
module tfd_out_stage import tfd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  out_ctl_t ctl_i,
  output logic     free_o,
  tfd_out_if.source out_o
);

  logic valid_q, valid_d;
  rec_t rec_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (out_o.ready) valid_d = 1'b0;
    if (ctl_i.load && free_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // hold the word until taken
  always_ff @(posedge clk_i) begin
    if (ctl_i.load && free_o) rec_q <= ctl_i.rec;
  end

  assign out_o.valid          = valid_q;
  assign out_o.record_index   = rec_q.record_index;
  assign out_o.version_byte   = rec_q.version_byte;
  assign out_o.terminal_id    = rec_q.terminal_id;
  assign out_o.status_word    = rec_q.status_word;
  assign out_o.occupied_flag  = rec_q.occupied_flag;
  assign out_o.alarm_flag     = rec_q.alarm_flag;
  assign out_o.mileage        = rec_q.mileage;
  assign out_o.has_gps_data   = rec_q.has_gps_data;
  assign out_o.last_of_parcel = rec_q.last_of_parcel;

endmodule

[rtl/core/tracker_tlv_frame_decoder.sv]
// Tracker frame decoder. Parcel bytes enter one word per handshake. Frame
// bytes are kept in a 256-entry byte memory (one write and one read a cycle,
// registered read data). A byte that neither closes a frame nor ends a
// parcel is taken without leaving the idle state. A closing 0xF8 starts a
// walk of the stored frame: each byte read passes a read and a data state,
// first for version and terminal id, then per TLV a check state is followed
// by reads of the type and length bytes and, for status and mileage TLVs,
// of the value bytes. A parcel end passes an end state that sends the final
// record. A record that must go out while the output register still holds
// an untaken word stalls the walk until that word leaves.
// Record fields never sent in a frame read zero; a lone record without GPS
// is dropped at parcel end.
module tracker_tlv_frame_decoder import tfd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  tfd_in_if.sink    in_i,
  tfd_out_if.source out_o
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OPEN = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DAT  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_END  = 3'd6;

  // walk phases: which byte the memory read returns
  localparam logic [2:0] P_VER  = 3'd0;
  localparam logic [2:0] P_ID   = 3'd1;
  localparam logic [2:0] P_TYPE = 3'd2;
  localparam logic [2:0] P_LEN  = 3'd3;
  localparam logic [2:0] P_V0   = 3'd4;
  localparam logic [2:0] P_V1   = 3'd5;
  localparam logic [2:0] P_V2   = 3'd6;
  localparam logic [2:0] P_V3   = 3'd7;

  // start-of-frame hunt
  localparam logic [1:0] H_HUNT  = 2'd0;
  localparam logic [1:0] H_CAND  = 2'd1;
  localparam logic [1:0] H_FRAME = 2'd2;

  logic [2:0]        state_q, state_d;
  logic [2:0]        phase_q, phase_d;
  logic [1:0]        hunt_q, hunt_d;
  logic [FLEN_W-1:0] flen_q, flen_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              gps_q, gps_d;
  logic              end_q, end_d;
  logic [7:0]        ver_q, ver_d;
  logic [55:0]       id_q, id_d;
  logic [15:0]       status_q, status_d;
  logic              alarm_q, alarm_d;
  logic [15:0]       mile_q, mile_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  rd_addr_q, rd_addr_d;
  logic [7:0]        type_q, type_d;
  logic [7:0]        v0_q, v0_d;

  logic              in_fire;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_rdata;
  logic [7:0]        rbyte;
  logic              out_free;
  logic              open_slot;
  logic              keep_last;
  logic [IDX_W-1:0]  idx_full;
  out_ctl_t          out_ctl;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  tfd_ram #(.DEPTH(FRAME_BYTES), .WIDTH(8)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_i.data_byte),
    .raddr_i (rd_addr_q[ADDR_W-1:0]),
    .rdata_o (mem_rdata)
  );

  // bytes at or past the closing mark read zero
  assign rbyte = (rd_addr_q < POS_W'(flen_q)) ? mem_rdata : 8'h00;

  assign open_slot = gps_q && (slot_q < SLOT_W'(MAX_SLOTS - 1));
  assign keep_last = (slot_q != '0) && !(!gps_q && slot_q == SLOT_W'(1));
  assign idx_full  = IDX_W'(slot_q) - IDX_W'(1);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    hunt_d    = hunt_q;
    flen_d    = flen_q;
    slot_d    = slot_q;
    gps_d     = gps_q;
    end_d     = end_q;
    ver_d     = ver_q;
    id_d      = id_q;
    status_d  = status_q;
    alarm_d   = alarm_q;
    mile_d    = mile_q;
    pos_d     = pos_q;
    rd_addr_d = rd_addr_q;
    type_d    = type_q;
    v0_d      = v0_q;
    mem_we    = 1'b0;
    mem_waddr = flen_q[ADDR_W-1:0];

    out_ctl.load                    = 1'b0;
    out_ctl.rec.record_index        = idx_full[5:0];
    out_ctl.rec.version_byte        = ver_q;
    out_ctl.rec.terminal_id         = id_q;
    out_ctl.rec.status_word         = status_q;
    out_ctl.rec.occupied_flag       = status_q[8];
    out_ctl.rec.alarm_flag          = alarm_q;
    out_ctl.rec.mileage             = mile_q;
    out_ctl.rec.has_gps_data        = gps_q;
    out_ctl.rec.last_of_parcel      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          end_d   = in_i.parcel_end;
          state_d = in_i.parcel_end ? S_END : S_IDLE;
          case (hunt_q)
            H_FRAME: begin
              if (in_i.data_byte == MARK) begin
                state_d = S_OPEN;
              end else if (flen_q < FLEN_W'(FRAME_BYTES)) begin
                mem_we = 1'b1;
                flen_d = flen_q + FLEN_W'(1);
              end
            end
            H_CAND: begin
              // byte 0 is never read back; store only byte 1
              if (in_i.data_byte != MARK) begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(VER_OFS);
                flen_d    = FLEN_W'(2);
                hunt_d    = H_FRAME;
              end
            end
            default: begin
              hunt_d = (in_i.data_byte == MARK) ? H_CAND : H_HUNT;
            end
          endcase
        end
      end

      S_OPEN: begin
        rd_addr_d = POS_W'(VER_OFS);
        phase_d   = P_VER;
        if (!open_slot) begin
          state_d = S_RD;
        end else if (slot_q == '0 || out_free) begin
          // finalize the previous record, then open a cleared slot
          out_ctl.load = (slot_q != '0);
          slot_d   = slot_q + SLOT_W'(1);
          gps_d    = 1'b0;
          ver_d    = '0;
          id_d     = '0;
          status_d = '0;
          alarm_d  = 1'b0;
          mile_d   = '0;
          state_d  = S_RD;
        end
      end

      S_RD: begin
        state_d = S_DAT;
      end

      S_DAT: begin
        state_d = S_RD;
        case (phase_q)
          P_VER: begin
            ver_d     = rbyte;
            rd_addr_d = POS_W'(ID_FIRST);
            phase_d   = P_ID;
          end
          P_ID: begin
            id_d = {id_q[47:0], rbyte};
            if (rd_addr_q == POS_W'(ID_LAST)) begin
              pos_d   = POS_W'(TLV_START);
              state_d = S_CHK;
            end else begin
              rd_addr_d = rd_addr_q + POS_W'(1);
            end
          end
          P_TYPE: begin
            type_d    = rbyte;
            rd_addr_d = pos_q + POS_W'(1);
            phase_d   = P_LEN;
          end
          P_LEN: begin
            pos_d     = pos_q + POS_W'(2) + POS_W'(rbyte);
            rd_addr_d = pos_q + POS_W'(2);
            phase_d   = P_V0;
            if (type_q == TLV_GPS) gps_d = 1'b1;
            if (type_q != TLV_STATUS && type_q != TLV_MILE) state_d = S_CHK;
          end
          P_V0: begin
            v0_d      = rbyte;
            rd_addr_d = rd_addr_q + POS_W'(1);
            phase_d   = P_V1;
          end
          P_V1: begin
            if (type_q == TLV_MILE) begin
              mile_d  = {v0_q, rbyte};
              state_d = S_CHK;
            end else begin
              status_d  = {rbyte, v0_q};
              rd_addr_d = rd_addr_q + POS_W'(1);
              phase_d   = P_V2;
            end
          end
          P_V2: begin
            rd_addr_d = rd_addr_q + POS_W'(1);
            phase_d   = P_V3;
          end
          default: begin
            // alarm mask 512 is bit 1 of the high byte
            alarm_d = rbyte[1];
            state_d = S_CHK;
          end
        endcase
      end

      S_CHK: begin
        if ((pos_q + POS_W'(3)) < POS_W'(flen_q)) begin
          rd_addr_d = pos_q;
          phase_d   = P_TYPE;
          state_d   = S_RD;
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        flen_d  = '0;
        hunt_d  = H_HUNT;
        state_d = end_q ? S_END : S_IDLE;
      end

      S_END: begin
        out_ctl.rec.last_of_parcel = 1'b1;
        if (!keep_last || out_free) begin
          out_ctl.load = keep_last;
          hunt_d   = H_HUNT;
          flen_d   = '0;
          slot_d   = '0;
          gps_d    = 1'b1;
          ver_d    = '0;
          id_d     = '0;
          status_d = '0;
          alarm_d  = 1'b0;
          mile_d   = '0;
          end_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= P_VER;
      hunt_q   <= H_HUNT;
      flen_q   <= '0;
      slot_q   <= '0;
      gps_q    <= 1'b1;
      end_q    <= 1'b0;
      ver_q    <= '0;
      id_q     <= '0;
      status_q <= '0;
      alarm_q  <= 1'b0;
      mile_q   <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      hunt_q   <= hunt_d;
      flen_q   <= flen_d;
      slot_q   <= slot_d;
      gps_q    <= gps_d;
      end_q    <= end_d;
      ver_q    <= ver_d;
      id_q     <= id_d;
      status_q <= status_d;
      alarm_q  <= alarm_d;
      mile_q   <= mile_d;
    end
  end

  // walk scratch
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    rd_addr_q <= rd_addr_d;
    type_q    <= type_d;
    v0_q      <= v0_d;
  end

  tfd_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (out_ctl),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

[rtl/core/tfd_checker.sv]
module tfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_end_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [5:0] out_index_i,
  input logic       out_gps_i,
  input logic [8:0] out_status_lo_i,
  input logic       out_occ_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_end_i |=> !in_ready_i)
    else $error("parcel end not processed before next byte");

  a_lone_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_index_i == 6'd0 && !out_gps_i |-> 1'b0)
    else $error("first record without GPS emitted");

  a_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_occ_i == out_status_lo_i[8])
    else $error("occupied flag disagrees with status word");

endmodule

bind tracker_tlv_frame_decoder tfd_checker u_tfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_end_i        (in_i.parcel_end),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_index_i     (out_o.record_index),
  .out_gps_i       (out_o.has_gps_data),
  .out_status_lo_i (out_o.status_word[8:0]),
  .out_occ_i       (out_o.occupied_flag)
);

[test/tracker_tlv_frame_decoder_checker.sv]
module tracker_tlv_frame_decoder_checker import tfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tfd_in_if    in_i,
  tfd_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {SEEK_MARK, MARK_SEEN, IN_FRAME} seek_e;

  rec_t        record_q[$];
  logic [7:0]  frame_mem[FRAME_BYTES];
  int          frame_len;
  seek_e       seek;
  int          slots_used;
  bit          gps_seen;
  logic [7:0]  acc_version;
  logic [55:0] acc_id;
  logic [15:0] acc_status;
  bit          acc_alarm;
  logic [15:0] acc_mileage;

  function automatic logic [7:0] frame_at(int i);
    return (i < frame_len && i < FRAME_BYTES) ? frame_mem[i] : 8'h00;
  endfunction

  function automatic void clear_record();
    acc_version = '0; acc_id = '0; acc_status = '0; acc_alarm = 0; acc_mileage = '0;
  endfunction

  function automatic void clear_parcel();
    seek = SEEK_MARK; frame_len = 0; slots_used = 0; gps_seen = 1;
    clear_record();
  endfunction

  function automatic void push_record(bit last);
    rec_t r;
    r.record_index   = 6'(slots_used - 1);
    r.version_byte   = acc_version;
    r.terminal_id    = acc_id;
    r.status_word    = acc_status;
    r.occupied_flag  = acc_status[8];
    r.alarm_flag     = acc_alarm;
    r.mileage        = acc_mileage;
    r.has_gps_data   = gps_seen;
    r.last_of_parcel = last;
    record_q.push_back(r);
  endfunction

  // Fold a closed frame into the current slot, opening a new one first if allowed.
  function automatic void close_frame();
    int pos;
    logic [7:0] kind;
    logic [15:0] alarm_word;
    if (gps_seen && slots_used < MAX_SLOTS - 1) begin
      if (slots_used > 0) push_record(0);
      slots_used++;
      gps_seen = 0;
      clear_record();
    end
    acc_version = frame_at(VER_OFS);
    acc_id = '0;
    for (int i = ID_FIRST; i <= ID_LAST; i++) acc_id = {acc_id[47:0], frame_at(i)};
    pos = TLV_START;
    while (pos + 3 < frame_len) begin
      kind = frame_at(pos);
      if (kind == TLV_GPS) begin
        gps_seen = 1;
      end else if (kind == TLV_STATUS) begin
        acc_status = {frame_at(pos + 3), frame_at(pos + 2)};
        alarm_word = {frame_at(pos + 5), frame_at(pos + 4)};
        acc_alarm  = (alarm_word & 16'd512) != 0;
      end else if (kind == TLV_MILE) begin
        acc_mileage = {frame_at(pos + 2), frame_at(pos + 3)};
      end
      pos += 2 + int'(frame_at(pos + 1));
    end
    frame_len = 0;
  endfunction

  function automatic void take_word(logic [7:0] b, bit last);
    case (seek)
      IN_FRAME: begin
        if (b == MARK) begin
          close_frame();
          seek = SEEK_MARK;
        end else if (frame_len < FRAME_BYTES) begin
          frame_mem[frame_len] = b;
          frame_len++;
        end
      end
      MARK_SEEN: begin
        if (b != MARK) begin
          frame_mem[0] = MARK;
          frame_mem[1] = b;
          frame_len = 2;
          seek = IN_FRAME;
        end
      end
      default: seek = (b == MARK) ? MARK_SEEN : SEEK_MARK;
    endcase
    if (last) begin
      // a single slot that never saw GPS is dropped
      if (slots_used > 0 && !(gps_seen == 0 && slots_used == 1)) push_record(1);
      clear_parcel();
    end
  endfunction

  initial begin
    clear_parcel();
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    rec_t got, want;
    if (rst_ni) begin
      if (in_i.valid && in_i.ready) take_word(in_i.data_byte, in_i.parcel_end);
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.record_index, out_i.version_byte, out_i.terminal_id,
                out_i.status_word, out_i.occupied_flag, out_i.alarm_flag,
                out_i.mileage, out_i.has_gps_data, out_i.last_of_parcel};
        if (record_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected record %p", got);
        end else begin
          want = record_q.pop_front();
          if (got.record_index !== want.record_index ||
              got.version_byte !== want.version_byte ||
              got.terminal_id !== want.terminal_id ||
              got.status_word !== want.status_word ||
              got.occupied_flag !== want.occupied_flag ||
              got.alarm_flag !== want.alarm_flag ||
              got.mileage !== want.mileage ||
              got.has_gps_data !== want.has_gps_data ||
              got.last_of_parcel !== want.last_of_parcel) begin
            fail_count_o++;
            if (fail_count_o <= 10) $display("record mismatch: expected %p got %p", want, got);
          end
        end
      end
      pending_o = record_q.size();
    end
  end
endmodule

[test/tracker_tlv_frame_decoder_tb.sv]
module tracker_tlv_frame_decoder_tb;
  import tfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   words_sent;

  tfd_in_if  in_w();
  tfd_out_if out_w();

  tracker_tlv_frame_decoder dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_w), .out_o(out_w));

  tracker_tlv_frame_decoder_checker checker_u (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_w), .out_i(out_w),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive receiver backpressure; the percentage changes with the traffic phase.
  always @(posedge clk_i) begin
    out_w.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Switch the idle mix as the run advances: sender-light, then receiver-light, then none.
  always @(posedge clk_i) begin
    if (words_sent < 450) begin
      tx_idle_pct <= 14; rx_idle_pct <= 61;
    end else if (words_sent < 900) begin
      tx_idle_pct <= 61; rx_idle_pct <= 14;
    end else begin
      tx_idle_pct <= 0; rx_idle_pct <= 0;
    end
  end

  logic [7:0] parcel_q[$];

  // Any byte but the frame mark; keeps frame contents from closing the frame early.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom);
    return (b == MARK) ? 8'hF7 : b;
  endfunction

  // Hold valid across back-to-back words; drop it only while idling.
  task automatic send_word(logic [7:0] b, bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_w.valid <= 0;
      @(posedge clk_i);
    end
    in_w.valid      <= 1;
    in_w.data_byte  <= b;
    in_w.parcel_end <= last;
    do @(posedge clk_i); while (!in_w.ready);
    words_sent++;
  endtask

  task automatic send_parcel();
    foreach (parcel_q[i]) send_word(parcel_q[i], i == parcel_q.size() - 1);
    parcel_q.delete();
  endtask

  // Append one frame: mark, version, spare byte, 7 id bytes, TLVs, closing mark if close_it is set.
  task automatic add_frame(bit gps, int tlvs, bit close_it);
    int gps_at;
    logic [7:0] kind;
    int len;
    gps_at = gps ? $urandom_range(0, (tlvs > 0) ? tlvs - 1 : 0) : -1;
    parcel_q.push_back(MARK);
    for (int i = 0; i < 9; i++) parcel_q.push_back(body_byte());
    for (int t = 0; t < tlvs; t++) begin
      case ($urandom_range(3))
        0: kind = TLV_STATUS;
        1: kind = TLV_MILE;
        2: kind = TLV_GPS;
        default: kind = body_byte();
      endcase
      if (t == gps_at) kind = TLV_GPS;
      else if (kind == TLV_GPS && !gps) kind = 8'h02;
      if (kind == TLV_STATUS) len = 4;
      else if (kind == TLV_MILE) len = 2;
      else len = $urandom_range(0, 6);
      // occasionally a length that runs past the frame end
      if ($urandom_range(19) == 0) len = $urandom_range(0, 255);
      parcel_q.push_back(kind);
      parcel_q.push_back(8'(len));
      for (int k = 0; k < len && k < 8; k++) parcel_q.push_back(body_byte());
    end
    if (close_it) parcel_q.push_back(MARK);
  endtask

  task automatic random_parcel();
    int frames;
    frames = $urandom_range(1, 5);
    for (int i = $urandom_range(0, 3); i > 0; i--)
      parcel_q.push_back(($urandom_range(3) == 0) ? MARK : body_byte());
    for (int f = 0; f < frames; f++) add_frame($urandom_range(99) < 60, $urandom_range(0, 4), 1);
    case ($urandom_range(9))
      0: parcel_q.push_back(body_byte());
      1: add_frame(1, 1, 0);
      default: ;
    endcase
  endtask

  initial begin
    in_w.valid = 0;
    in_w.data_byte = '0;
    in_w.parcel_end = 0;
    out_w.ready = 0;
    tx_idle_pct = 14;
    rx_idle_pct = 61;
    words_sent = 0;
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Repeated marks before a frame with every TLV kind and extreme field bytes.
    parcel_q = '{MARK, MARK, MARK, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'hFF, TLV_STATUS, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF, TLV_MILE, 8'h02,
                 8'hFF, 8'hFF, TLV_GPS, 8'h00, 8'h00, MARK};
    send_parcel();
    // Lone record without GPS: dropped.
    add_frame(0, 2, 1);
    send_parcel();
    // Frames merge into a non-GPS slot until a GPS frame; the frame after it opens the next slot.
    add_frame(0, 3, 1); add_frame(0, 3, 1); add_frame(1, 2, 1); add_frame(0, 2, 1);
    send_parcel();
    // Short frame, then a TLV length running past the frame end, all-zero id.
    parcel_q = '{MARK, 8'h00, MARK, MARK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, TLV_STATUS, 8'hFF, 8'h12, 8'h02, MARK};
    send_parcel();
    // Unclosed frame at parcel end.
    add_frame(1, 1, 1); add_frame(1, 2, 0);
    send_parcel();
    // Over-long frame: bytes past the store size are dropped.
    add_frame(1, 0, 0);
    parcel_q.push_back(TLV_MILE); parcel_q.push_back(8'h02);
    for (int i = 0; i < 250; i++) parcel_q.push_back(body_byte());
    parcel_q.push_back(MARK);
    send_parcel();
    // Slot cap: short GPS frames fill every slot, then a short frame merges into the last.
    for (int f = 0; f < MAX_SLOTS - 1; f++) begin
      parcel_q.push_back(MARK);
      for (int i = 0; i < 9; i++) parcel_q.push_back(body_byte());
      parcel_q.push_back(TLV_GPS); parcel_q.push_back(8'h00);
      parcel_q.push_back(body_byte()); parcel_q.push_back(body_byte());
      parcel_q.push_back(MARK);
    end
    parcel_q.push_back(MARK); parcel_q.push_back(8'h01); parcel_q.push_back(MARK);
    send_parcel();

    while (words_sent < 1150) begin
      random_parcel();
      send_parcel();
    end
    @(posedge clk_i);
    in_w.valid <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #9ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
